// ===== rtl/sld_pkg.sv =====
// Shared types, constants and helper functions for the sync length frame deframer.
package sld_pkg;

    localparam int LENGTH_BYTES = 4;
    localparam int LEN_W        = 8 * LENGTH_BYTES;
    localparam int CFG_W        = 21;
    localparam int CMP_W        = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int IDX_W        = 2;

    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = CFG_W'(4096);

    localparam logic [7:0] SYNC_CC = 8'hCC;
    localparam logic [7:0] SYNC_BB = 8'hBB;
    localparam logic [7:0] SYNC_AA = 8'hAA;

    localparam logic [IDX_W-1:0] SYNC_LAST_IDX = IDX_W'(2);
    localparam logic [IDX_W-1:0] LEN_LAST_IDX  = IDX_W'(LENGTH_BYTES - 1);

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_HEAD   = 2'd1;
    localparam logic [1:0] CAUSE_LENGTH = 2'd2;
    localparam logic [1:0] CAUSE_TAIL   = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_TAIL    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [CFG_W-1:0] length;
        logic [1:0]       cause;
        logic             last;
    } result_t;

    function automatic logic head_match(input logic [IDX_W-1:0] idx, input logic [7:0] b);
        logic m;
        case (idx)
            2'd0:    m = (b == SYNC_CC);
            2'd1:    m = (b == SYNC_BB);
            2'd2:    m = (b == SYNC_AA);
            default: m = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic tail_match(input logic [IDX_W-1:0] idx, input logic [7:0] b);
        logic m;
        case (idx)
            2'd0:    m = (b == SYNC_AA);
            2'd1:    m = (b == SYNC_BB);
            2'd2:    m = (b == SYNC_CC);
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/sld_in_stage.sv =====
// Input register stage holding one received byte until the core takes it.
module sld_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

// ===== rtl/sld_core.sv =====
// Frame parser: phase tracking, length check, payload count and result build.
module sld_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [sld_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                    item_valid,
    input  logic [7:0]              item_byte,
    input  logic                    out_free,
    output logic                    take,
    output logic                    res_valid,
    output sld_pkg::result_t        res
);

    sld_pkg::phase_t                phase_reg;
    sld_pkg::phase_t                phase_next;
    logic [sld_pkg::IDX_W-1:0]      idx_reg;
    logic [sld_pkg::IDX_W-1:0]      idx_next;
    logic [sld_pkg::LEN_W-1:0]      accum_reg;
    logic [sld_pkg::LEN_W-1:0]      accum_next;
    logic [sld_pkg::LEN_W-1:0]      accum_ins;
    logic [sld_pkg::CFG_W-1:0]      left_reg;
    logic [sld_pkg::CFG_W-1:0]      left_next;
    logic [sld_pkg::CFG_W-1:0]      max_reg;
    logic                           last_byte;

    assign take = item_valid && out_free;

    always_comb begin
        accum_ins = accum_reg;
        for (int k = 0; k < sld_pkg::LENGTH_BYTES; k++) begin
            if (idx_reg == sld_pkg::IDX_W'(k)) begin
                accum_ins[8*k +: 8] = item_byte;
            end
        end
    end

    assign last_byte = (left_reg <= sld_pkg::CFG_W'(1));

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        accum_next = accum_reg;
        left_next  = left_reg;
        res_valid  = 1'b0;
        res        = '0;
        case (phase_reg)
            sld_pkg::PH_HUNT: begin
                if (sld_pkg::head_match(idx_reg, item_byte)) begin
                    if (idx_reg == sld_pkg::SYNC_LAST_IDX) begin
                        phase_next = sld_pkg::PH_LENGTH;
                        idx_next   = '0;
                        accum_next = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    idx_next   = '0;
                    accum_next = '0;
                    left_next  = '0;
                    res_valid  = 1'b1;
                    res.kind   = sld_pkg::KIND_REJECT;
                    res.cause  = sld_pkg::CAUSE_HEAD;
                end
            end
            sld_pkg::PH_LENGTH: begin
                accum_next = accum_ins;
                if (idx_reg != sld_pkg::LEN_LAST_IDX) begin
                    idx_next = idx_reg + 1'b1;
                end else if (accum_ins[sld_pkg::LEN_W-1] ||
                             (sld_pkg::CMP_W'(accum_ins) > sld_pkg::CMP_W'(max_reg))) begin
                    phase_next = sld_pkg::PH_HUNT;
                    idx_next   = '0;
                    accum_next = '0;
                    left_next  = '0;
                    res_valid  = 1'b1;
                    res.kind   = sld_pkg::KIND_REJECT;
                    res.cause  = sld_pkg::CAUSE_LENGTH;
                end else begin
                    idx_next   = '0;
                    left_next  = sld_pkg::CFG_W'(accum_ins);
                    phase_next = (accum_ins == '0) ? sld_pkg::PH_TAIL : sld_pkg::PH_PAYLOAD;
                end
            end
            sld_pkg::PH_PAYLOAD: begin
                res_valid = 1'b1;
                res.kind  = sld_pkg::KIND_DATA;
                res.data  = item_byte;
                res.last  = last_byte;
                left_next = left_reg - 1'b1;
                if (last_byte) begin
                    left_next  = '0;
                    phase_next = sld_pkg::PH_TAIL;
                    idx_next   = '0;
                end
            end
            sld_pkg::PH_TAIL: begin
                if (sld_pkg::tail_match(idx_reg, item_byte)) begin
                    if (idx_reg != sld_pkg::SYNC_LAST_IDX) begin
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        res_valid  = 1'b1;
                        res.kind   = sld_pkg::KIND_ACCEPT;
                        res.length = sld_pkg::CFG_W'(accum_reg);
                        phase_next = sld_pkg::PH_HUNT;
                        idx_next   = '0;
                        accum_next = '0;
                        left_next  = '0;
                    end
                end else begin
                    phase_next = sld_pkg::PH_HUNT;
                    idx_next   = '0;
                    accum_next = '0;
                    left_next  = '0;
                    res_valid  = 1'b1;
                    res.kind   = sld_pkg::KIND_REJECT;
                    res.cause  = sld_pkg::CAUSE_TAIL;
                end
            end
            default: begin
                phase_next = sld_pkg::PH_HUNT;
                idx_next   = '0;
                accum_next = '0;
                left_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sld_pkg::PH_HUNT;
            idx_reg   <= '0;
            accum_reg <= '0;
            left_reg  <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            accum_reg <= accum_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= sld_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_wr_en) begin
            max_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== rtl/sld_out_stage.sv =====
// Result register holding one result item until the sink takes it.
module sld_out_stage (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  sld_pkg::result_t          res,
    output logic                      out_free,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_out_kind,
    output logic [7:0]                m_data_byte,
    output logic [sld_pkg::CFG_W-1:0] m_frame_length,
    output logic [1:0]                m_reject_cause,
    output logic                      m_last_payload
);

    logic             valid_reg;
    logic             valid_next;
    sld_pkg::result_t res_reg;

    assign out_free       = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_out_kind     = res_reg.kind;
    assign m_data_byte    = res_reg.data;
    assign m_frame_length = res_reg.length;
    assign m_reject_cause = res_reg.cause;
    assign m_last_payload = res_reg.last;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/sync_length_frame_deframer.sv =====
// Top level of the sync length frame deframer: input stage, parser core, result stage.
// Accepted bytes pass the input register, then results pass the result register to m_*.
// Throughput: one input item per cycle, limited only by m_ready backpressure.
// Each input byte gives zero or one result item; stalls propagate from m_ready to s_ready.
// Reset (aresetn low, synchronous): hunt for head, empty stages, max_payload = 4096.
module sync_length_frame_deframer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [sld_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_out_kind,
    output logic [7:0]                m_data_byte,
    output logic [sld_pkg::CFG_W-1:0] m_frame_length,
    output logic [1:0]                m_reject_cause,
    output logic                      m_last_payload
);

    logic             take;
    logic             item_valid;
    logic [7:0]       item_byte;
    logic             out_free;
    logic             res_valid;
    sld_pkg::result_t res;

    sld_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    sld_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_byte   (item_byte),
        .out_free    (out_free),
        .take        (take),
        .res_valid   (res_valid),
        .res         (res)
    );

    sld_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (take && res_valid),
        .res            (res),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_data_byte    (m_data_byte),
        .m_frame_length (m_frame_length),
        .m_reject_cause (m_reject_cause),
        .m_last_payload (m_last_payload)
    );

endmodule

// ===== sim/tb.sv =====
// Testbench for sync_length_frame_deframer: random framed byte streams checked by a scoreboard.
`timescale 1ns / 1ps

localparam logic [7:0] HEAD_SEQ [3] = '{sld_pkg::SYNC_CC, sld_pkg::SYNC_BB, sld_pkg::SYNC_AA};
localparam logic [7:0] TAIL_SEQ [3] = '{sld_pkg::SYNC_AA, sld_pkg::SYNC_BB, sld_pkg::SYNC_CC};

class deframe_scoreboard;
    logic [sld_pkg::CFG_W-1:0] max_payload;
    sld_pkg::phase_t           phase;
    int unsigned               idx;
    logic [sld_pkg::LEN_W-1:0] len_accum;
    logic [sld_pkg::CFG_W-1:0] left;
    sld_pkg::result_t          expected_q[$];
    int unsigned               errors;

    function new();
        max_payload = sld_pkg::MAX_PAYLOAD_RESET;
        errors = 0;
        restart();
    endfunction

    function void restart();
        phase = sld_pkg::PH_HUNT;
        idx = 0;
        len_accum = '0;
        left = '0;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] data, logic [sld_pkg::CFG_W-1:0] length,
                       logic [1:0] cause, logic last);
        sld_pkg::result_t r;
        r.kind = kind;
        r.data = data;
        r.length = length;
        r.cause = cause;
        r.last = last;
        expected_q.push_back(r);
    endfunction

    function void reject(logic [1:0] cause);
        restart();
        push(sld_pkg::KIND_REJECT, 8'd0, '0, cause, 1'b0);
    endfunction

    function void note_byte(logic [7:0] b);
        logic fin;
        case (phase)
            sld_pkg::PH_HUNT: begin
                if (b != HEAD_SEQ[idx]) begin
                    reject(sld_pkg::CAUSE_HEAD);
                end else if (idx == 2) begin
                    phase = sld_pkg::PH_LENGTH;
                    idx = 0;
                    len_accum = '0;
                end else begin
                    idx++;
                end
            end
            sld_pkg::PH_LENGTH: begin
                len_accum[8*idx +: 8] = b;
                if (idx != sld_pkg::LENGTH_BYTES - 1) begin
                    idx++;
                end else if (len_accum[sld_pkg::LEN_W-1] || len_accum > max_payload) begin
                    reject(sld_pkg::CAUSE_LENGTH);
                end else begin
                    idx = 0;
                    left = len_accum[sld_pkg::CFG_W-1:0];
                    phase = (left == 0) ? sld_pkg::PH_TAIL : sld_pkg::PH_PAYLOAD;
                end
            end
            sld_pkg::PH_PAYLOAD: begin
                fin = (left <= 1);
                left = left - 1'b1;
                if (fin) begin
                    left = '0;
                    phase = sld_pkg::PH_TAIL;
                    idx = 0;
                end
                push(sld_pkg::KIND_DATA, b, '0, sld_pkg::CAUSE_NONE, fin);
            end
            default: begin
                if (b != TAIL_SEQ[idx]) begin
                    reject(sld_pkg::CAUSE_TAIL);
                end else if (idx != 2) begin
                    idx++;
                end else begin
                    push(sld_pkg::KIND_ACCEPT, 8'd0, len_accum[sld_pkg::CFG_W-1:0],
                         sld_pkg::CAUSE_NONE, 1'b0);
                    restart();
                end
            end
        endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data,
                               logic [sld_pkg::CFG_W-1:0] length,
                               logic [1:0] cause, logic last);
        sld_pkg::result_t want;
        if (expected_q.size() == 0) begin
            $error("unexpected result item: out_kind %0d", kind);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (kind !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
        end
        if (data !== want.data) begin
            $error("data_byte: expected %0d, actual %0d", want.data, data);
            errors++;
        end
        if (length !== want.length) begin
            $error("frame_length: expected %0d, actual %0d", want.length, length);
            errors++;
        end
        if (cause !== want.cause) begin
            $error("reject_cause: expected %0d, actual %0d", want.cause, cause);
            errors++;
        end
        if (last !== want.last) begin
            $error("last_payload: expected %0d, actual %0d", want.last, last);
            errors++;
        end
    endfunction
endclass

module tb;
    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [sld_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [7:0]                s_rx_byte = 8'd0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [1:0]                m_out_kind;
    logic [7:0]                m_data_byte;
    logic [sld_pkg::CFG_W-1:0] m_frame_length;
    logic [1:0]                m_reject_cause;
    logic                      m_last_payload;

    deframe_scoreboard sb;
    int unsigned       burst_left = 0;
    int unsigned       bytes_sent = 0;
    bit                hold_req = 1'b0;

    sync_length_frame_deframer u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_data_byte    (m_data_byte),
        .m_frame_length (m_frame_length),
        .m_reject_cause (m_reject_cause),
        .m_last_payload (m_last_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random ready segments, plus one long hold-off on request
    initial begin
        int unsigned seg;
        int unsigned mode;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (400) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end else begin
                seg = $urandom_range(10, 150);
                mode = $urandom_range(0, 3);
                repeat (seg) begin
                    @(negedge aclk);
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= ($urandom_range(0, 7) == 0);
                        default: m_ready <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_kind, m_data_byte, m_frame_length, m_reject_cause,
                            m_last_payload);
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned pick;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            pick = $urandom_range(0, 9);
            gap = (pick < 4) ? 0 : (pick < 8) ? $urandom_range(1, 3) :
                  (pick == 8) ? $urandom_range(4, 10) : $urandom_range(11, 30);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    // drop valid, wait for every expected item, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_max(input logic [sld_pkg::CFG_W-1:0] v);
        settle();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.max_payload = v;
    endtask

    task automatic send_mixed_frame();
        int unsigned               pick;
        int unsigned               k;
        int unsigned               r;
        int unsigned               cap;
        logic [sld_pkg::LEN_W-1:0] n;
        logic [sld_pkg::LEN_W-1:0] top;
        logic [7:0]                b;
        pick = $urandom_range(0, 99);
        if (pick >= 92) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            return;
        end
        if (pick >= 65 && pick < 72) begin
            k = $urandom_range(0, 2);
            for (int i = 0; i < k; i++) send_byte(HEAD_SEQ[i]);
            do b = 8'($urandom); while (b == HEAD_SEQ[k]);
            send_byte(b);
            return;
        end
        foreach (HEAD_SEQ[i]) send_byte(HEAD_SEQ[i]);
        top = sld_pkg::LEN_W'(sb.max_payload) + 1'b1;
        if (pick >= 72 && pick < 78) begin
            n = ($urandom_range(0, 3) == 0) ? '1 : {1'b1, 31'($urandom)};
        end else if (pick >= 78 && pick < 84) begin
            n = ($urandom_range(0, 1) == 0) ? top :
                top + $urandom_range(0, 32'h7FFF_FFFF - top);
        end else if (sb.max_payload == 0) begin
            n = '0;
        end else begin
            cap = (sb.max_payload < 48) ? sb.max_payload : 48;
            r = $urandom_range(0, 9);
            if (r == 0)
                n = '0;
            else if (r < 8)
                n = $urandom_range(1, (cap < 8) ? cap : 8);
            else if (r == 8)
                n = $urandom_range(1, cap);
            else
                n = cap;
        end
        for (int i = 0; i < sld_pkg::LENGTH_BYTES; i++) send_byte(n[8*i +: 8]);
        if (pick >= 72 && pick < 84)
            return;
        repeat (n) send_byte(8'($urandom));
        if (pick >= 84) begin
            k = $urandom_range(0, 2);
            for (int i = 0; i < k; i++) send_byte(TAIL_SEQ[i]);
            do b = 8'($urandom); while (b == TAIL_SEQ[k]);
            send_byte(b);
        end else begin
            foreach (TAIL_SEQ[i]) send_byte(TAIL_SEQ[i]);
        end
    endtask

    initial begin
        logic [7:0]                seq[$];
        logic [sld_pkg::CFG_W-1:0] v;
        int unsigned               phase_end;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        seq = '{8'h00, 8'hFF,
                8'hCC, 8'hCC,
                8'hCC, 8'hBB, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hBB, 8'hCC,
                8'hCC, 8'hBB, 8'hAA, 8'h01, 8'h00, 8'h00, 8'h00, 8'h5A,
                8'hAA, 8'hBB, 8'hCC,
                8'hCC, 8'hBB, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h80,
                8'hCC, 8'hBB, 8'hAA, 8'h01, 8'h10, 8'h00, 8'h00,
                8'hCC, 8'hBB, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hBB, 8'h00};
        foreach (seq[i]) send_byte(seq[i]);

        for (int p = 0; p < 5; p++) begin
            case (p)
                0: v = '0;
                1: v = sld_pkg::CFG_W'(1048576);
                2: v = sld_pkg::CFG_W'(16);
                3: v = sld_pkg::MAX_PAYLOAD_RESET;
                default: v = sld_pkg::CFG_W'($urandom_range(1, 48));
            endcase
            write_max(v);
            if (p == 0)
                hold_req = 1'b1;
            phase_end = bytes_sent + 340;
            while (bytes_sent < phase_end) send_mixed_frame();
        end

        settle();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.expected_q.size() != 0)
                $error("%0d expected result items never arrived", sb.expected_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
